// File: rtl/core/lsbpe_pkg.sv
package lsbpe_pkg;

  localparam int unsigned TICK_W       = 15;
  localparam int unsigned TYPE_W       = 3;
  localparam int unsigned PIXEL_W      = 24;
  localparam int unsigned PULSE_CNT_W  = 5;

  localparam logic [PULSE_CNT_W-1:0] LAST_PULSE = PULSE_CNT_W'(PIXEL_W - 1);

  // Strip type codes.
  localparam logic [TYPE_W-1:0] STRIP_NULL    = 3'd0;
  localparam logic [TYPE_W-1:0] STRIP_WS2812  = 3'd1;
  localparam logic [TYPE_W-1:0] STRIP_WS2812B = 3'd2;
  localparam logic [TYPE_W-1:0] STRIP_WS2812D = 3'd3;
  localparam logic [TYPE_W-1:0] STRIP_GENERIC = 3'd4;

  // Timings in 50 ns ticks, truncated.
  typedef struct packed {
    logic [TICK_W-1:0] t0h;
    logic [TICK_W-1:0] t0l;
    logic [TICK_W-1:0] t1h;
    logic [TICK_W-1:0] t1l;
    logic [TICK_W-1:0] trs;
  } timing_t;

  // One pixel as it waits between the front and the back.
  typedef struct packed {
    logic [PIXEL_W-1:0] word;
    logic               final_pixel;
    logic [TYPE_W-1:0]  strip_type;
  } pixel_entry_t;

  function automatic logic strip_active(input logic [TYPE_W-1:0] st);
    return (st inside {[STRIP_WS2812:STRIP_GENERIC]});
  endfunction

  function automatic timing_t strip_timing(input logic [TYPE_W-1:0] st);
    timing_t t;
    case (st)
      STRIP_WS2812:  t = '{t0h: 15'd7, t0l: 15'd16, t1h: 15'd14, t1l: 15'd12, trs: 15'd1000};
      STRIP_WS2812B: t = '{t0h: 15'd6, t0l: 15'd21, t1h: 15'd21, t1l: 15'd6,  trs: 15'd5600};
      STRIP_WS2812D: t = '{t0h: 15'd8, t0l: 15'd17, t1h: 15'd16, t1l: 15'd9,  trs: 15'd1000};
      STRIP_GENERIC: t = '{t0h: 15'd8, t0l: 15'd17, t1h: 15'd17, t1l: 15'd8,  trs: 15'd1000};
      default:       t = '0;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/core/lsbpe_front.sv
module lsbpe_front
  import lsbpe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [TYPE_W-1:0]  cfg_strip_type,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_red,
  input  logic [7:0]         in_green,
  input  logic [7:0]         in_blue,
  input  logic               in_final_pixel,
  output logic               push_valid,
  input  logic               push_ready,
  output pixel_entry_t       push_entry
);

  logic [TYPE_W-1:0] strip_type_r;
  logic              stage_valid_r, stage_valid_nxt;
  pixel_entry_t      stage_r;
  logic              accept;

  assign in_ready   = !stage_valid_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = stage_valid_r;
  assign push_entry = stage_r;

  // Pixels for a null or unknown strip type are taken and dropped here.
  always_comb begin
    stage_valid_nxt = stage_valid_r && !push_ready;
    if (accept && strip_active(strip_type_r)) begin
      stage_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_type_r  <= STRIP_NULL;
      stage_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        strip_type_r <= cfg_strip_type;
      end
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r.word        <= {in_green, in_red, in_blue};
      stage_r.final_pixel <= in_final_pixel;
      stage_r.strip_type  <= strip_type_r;
    end
  end

endmodule

// File: rtl/core/lsbpe_queue.sv
module lsbpe_queue
  import lsbpe_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  pixel_entry_t push_entry,
  output logic         pop_valid,
  input  logic         pop_ready,
  output pixel_entry_t pop_entry
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pixel_entry_t     slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_ready && pop_valid;
  assign pop_entry  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: rtl/core/lsbpe_back.sv
module lsbpe_back
  import lsbpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  pixel_entry_t      pop_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TICK_W-1:0] out_high_ticks,
  output logic [TICK_W-1:0] out_low_ticks,
  output logic              out_bit_value,
  output logic              out_pixel_done,
  output logic              out_frame_done
);

  logic                   busy_r, busy_nxt;
  pixel_entry_t           cur_r;
  logic [PULSE_CNT_W-1:0] cnt_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [TICK_W-1:0]      high_r, low_r;
  logic                   bit_r, pixel_done_r, frame_done_r;

  timing_t                tm;
  logic                   cur_bit, last, emit, load;

  assign tm      = strip_timing(cur_r.strip_type);
  assign cur_bit = cur_r.word[PIXEL_W-1];
  assign last    = (cnt_r == LAST_PULSE);
  assign emit    = busy_r && (!out_valid_r || out_ready);
  // The next pixel is taken in the cycle the last pulse goes out, so pixels run gap-free.
  assign load    = pop_valid && (!busy_r || (emit && last));
  assign pop_ready = !busy_r || (emit && last);

  always_comb begin
    busy_nxt = busy_r;
    if (emit && last) begin
      busy_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= pop_entry;
      cnt_r <= '0;
    end else if (emit) begin
      cur_r.word <= {cur_r.word[PIXEL_W-2:0], 1'b0};
      cnt_r      <= cnt_r + 1'b1;
    end
    if (emit) begin
      high_r       <= cur_bit ? tm.t1h : tm.t0h;
      low_r        <= (last && cur_r.final_pixel) ? tm.trs : (cur_bit ? tm.t1l : tm.t0l);
      bit_r        <= cur_bit;
      pixel_done_r <= last;
      frame_done_r <= last && cur_r.final_pixel;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_high_ticks = high_r;
  assign out_low_ticks  = low_r;
  assign out_bit_value  = bit_r;
  assign out_pixel_done = pixel_done_r;
  assign out_frame_done = frame_done_r;

endmodule

// File: rtl/core/led_strip_bit_pulse_encoder.sv
// LED strip bit pulse encoder.
// The input channel takes one pixel (red, green, blue and a flag for the
// frame's last pixel). The result channel gives 24 pulses per pixel, green,
// red, then blue, most significant bit first, each with its high and low time
// in 50 ns ticks; the frame's final pulse carries the reset time as low time.
// The configuration channel writes the strip type; a null or unknown type
// makes the block take pixels and give no pulses.
// A pixel passes the front stage, the queue and the generator's pixel register
// before its first pulse is registered. The generator issues one pulse per cycle
// while the receiver takes them, so in steady state a pixel is taken per 24
// pulses; a queue of QUEUE_DEPTH pixels plus one front stage lets the input run ahead.
// A stalled receiver holds the result register, the generator waits, and the
// input stops once the queue and front stage are full.
// Reset empties all stages and sets the strip type to null.
module led_strip_bit_pulse_encoder
  import lsbpe_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TYPE_W-1:0] cfg_strip_type,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  input  logic              in_final_pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TICK_W-1:0] out_high_ticks,
  output logic [TICK_W-1:0] out_low_ticks,
  output logic              out_bit_value,
  output logic              out_pixel_done,
  output logic              out_frame_done
);

  logic         push_valid, push_ready;
  pixel_entry_t push_entry;
  logic         pop_valid, pop_ready;
  pixel_entry_t pop_entry;

  assign cfg_ready = 1'b1;

  lsbpe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_strip_type (cfg_strip_type),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_final_pixel (in_final_pixel),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_entry     (push_entry)
  );

  lsbpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  lsbpe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_entry      (pop_entry),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_high_ticks (out_high_ticks),
    .out_low_ticks  (out_low_ticks),
    .out_bit_value  (out_bit_value),
    .out_pixel_done (out_pixel_done),
    .out_frame_done (out_frame_done)
  );

endmodule
